/* hdl/obc_pkg.sv */
`default_nettype none
package obc_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int ROT_STEPS = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int IDX_W = $clog2(ATAN_ENTRIES);

  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int ONE_Q14      = 16384;
  localparam int RADIUS_RESET = 256;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // z = r*2^21/45 split as r*Z_INT + floor(17r/45); 17r/45 by reciprocal
  localparam int Z_INT   = 46603;
  localparam int Z_FRAC  = 17;
  localparam int RECIP45 = 745655;
  localparam int RECIP_SH = 25;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_VIEW_X = 2'd1,
    OP_VIEW_Y = 2'd2,
    OP_VIEW_Z = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MS_UP_X  = 3'd0,
    MS_UP_Y  = 3'd1,
    MS_W_X   = 3'd2,
    MS_W_Y   = 3'd3,
    MS_EYE_X = 3'd4,
    MS_EYE_Y = 3'd5,
    MS_EYE_Z = 3'd6
  } mul_step_t;

  typedef struct packed {
    logic             update;
    logic             reduce;
    logic             seed;
    logic             rotate;
    logic             finish;
    logic             sel;      // 0 azimuth, 1 inclination
    logic [IDX_W-1:0] idx;
    logic             mul;
    mul_step_t        mstep;
    logic             load_out;
  } obc_cmd_t;

  function automatic logic signed [31:0] atan_lut(input logic [IDX_W-1:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051D;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2E;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2F9;
      5'd15: v = 32'sh0000517C;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A2F;
      5'd19: v = 32'sh00000517;
      5'd20: v = 32'sh0000028B;
      5'd21: v = 32'sh00000145;
      5'd22: v = 32'sh000000A2;
      5'd23: v = 32'sh00000051;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/obc_ctrl.sv */
`default_nettype none
module obc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            out_tready,
  output logic                 out_tvalid,
  output obc_pkg::obc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_SEED, S_ROT, S_FIN, S_MUL, S_DONE
  } state_t;

  state_t                      state_r;
  logic [obc_pkg::IDX_W-1:0]   cnt_r;
  logic                        sel_r;
  obc_pkg::mul_step_t          mstep_r;
  logic                        out_valid_r;
  logic                        slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd          = '0;
    cmd.sel      = sel_r;
    cmd.idx      = cnt_r;
    cmd.mstep    = mstep_r;
    cmd.update   = (state_r == S_IDLE) && in_tvalid;
    cmd.reduce   = (state_r == S_RED);
    cmd.seed     = (state_r == S_SEED);
    cmd.rotate   = (state_r == S_ROT);
    cmd.finish   = (state_r == S_FIN);
    cmd.mul      = (state_r == S_MUL);
    cmd.load_out = (state_r == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      mstep_r     <= obc_pkg::MS_UP_X;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sel_r   <= 1'b0;
            state_r <= S_RED;
          end
        end
        S_RED:  state_r <= S_SEED;
        S_SEED: begin
          cnt_r   <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == obc_pkg::IDX_W'(obc_pkg::ROT_STEPS - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_RED;
          end else begin
            mstep_r <= obc_pkg::MS_UP_X;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mstep_r == obc_pkg::MS_EYE_Z) state_r <= S_DONE;
          else mstep_r <= obc_pkg::mul_step_t'(mstep_r + 3'd1);
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (cnt_r < obc_pkg::IDX_W'(obc_pkg::ROT_STEPS)))
    else $error("rotation index out of range");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

/* hdl/obc_dp.sv */
`default_nettype none
module obc_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire obc_pkg::obc_cmd_t    cmd,
  input  wire logic [1:0]           in_op,
  input  wire logic [17:0]          in_az_delta,
  input  wire logic [16:0]          in_inc_delta,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_radius,
  output logic [199:0]              out_data
);

  logic signed [17:0] az_r;
  logic [15:0]        inc_r;
  logic [15:0]        radius_r;

  // angle update
  logic signed [18:0] az_sum;
  logic signed [17:0] inc_sum;
  logic signed [17:0] az_nxt;
  logic [15:0]        inc_nxt;

  assign az_sum  = {az_r[17], az_r} + {in_az_delta[17], in_az_delta};
  assign inc_sum = {2'b00, inc_r} + {in_inc_delta[16], in_inc_delta};

  always_comb begin
    az_nxt  = az_r;
    inc_nxt = inc_r;
    unique case (obc_pkg::op_t'(in_op))
      obc_pkg::OP_UPDATE: begin
        if (az_sum > 19'sd92160 || az_sum < -19'sd92160) az_nxt = '0;
        else az_nxt = az_sum[17:0];
        if (inc_sum > 18'sd46080) inc_nxt = 16'(obc_pkg::HALF_TURN);
        else if (inc_sum < 18'sd0) inc_nxt = '0;
        else inc_nxt = inc_sum[15:0];
      end
      obc_pkg::OP_VIEW_X: begin
        az_nxt  = '0;
        inc_nxt = 16'(obc_pkg::QUARTER_TURN);
      end
      obc_pkg::OP_VIEW_Y: begin
        az_nxt  = 18'(obc_pkg::QUARTER_TURN);
        inc_nxt = 16'(obc_pkg::QUARTER_TURN);
      end
      obc_pkg::OP_VIEW_Z: begin
        az_nxt  = '0;
        inc_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_r     <= '0;
      inc_r    <= '0;
      radius_r <= 16'(obc_pkg::RADIUS_RESET);
    end else begin
      if (cmd.update) begin
        az_r  <= az_nxt;
        inc_r <= inc_nxt;
      end
      if (cfg_we) radius_r <= cfg_radius;
    end
  end

  // range reduction into quadrant and remainder
  logic signed [18:0] ang;
  logic signed [18:0] m_s;
  logic [16:0]        m;
  logic [1:0]         q_nxt;
  logic [14:0]        r_nxt;
  logic [1:0]         q_r;
  logic [14:0]        r_r;
  logic               rzero_r;

  assign ang = cmd.sel ? {3'b000, inc_r} : {az_r[17], az_r};
  assign m_s = (ang < 0) ? ang + 19'sd92160 : ang;

  always_comb begin
    m = (m_s == 19'sd92160) ? 17'd0 : m_s[16:0];
    if (m >= 17'd69120) begin
      q_nxt = 2'd3;
      r_nxt = 15'(m - 17'd69120);
    end else if (m >= 17'd46080) begin
      q_nxt = 2'd2;
      r_nxt = 15'(m - 17'd46080);
    end else if (m >= 17'd23040) begin
      q_nxt = 2'd1;
      r_nxt = 15'(m - 17'd23040);
    end else begin
      q_nxt = 2'd0;
      r_nxt = m[14:0];
    end
  end

  // binary angle and CORDIC
  logic [30:0]        z_int;
  logic [18:0]        r17;
  logic [38:0]        z_fprod;
  logic [31:0]        z_seed;
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [31:0] dx, dy, at;

  assign z_int   = 31'(r_r) * 31'(obc_pkg::Z_INT);
  assign r17     = 19'(r_r) * 19'(obc_pkg::Z_FRAC);
  assign z_fprod = 39'(r17) * 39'(obc_pkg::RECIP45);
  assign z_seed  = 32'(z_int) + 32'(z_fprod[38:obc_pkg::RECIP_SH]);
  assign dx = y_r >>> cmd.idx;
  assign dy = x_r >>> cmd.idx;
  assign at = obc_pkg::atan_lut(cmd.idx);

  // finishing: round Q30 to Q1.14, clamp, rotate into quadrant
  logic signed [32:0] xs, ys;
  logic signed [15:0] c0, s0, c_q, s_q;

  function automatic logic signed [15:0] clamp14(input logic signed [16:0] v);
    if (v > 17'sd16384) return 16'sd16384;
    if (v < -17'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  assign xs = ({x_r[31], x_r} + 33'sd32768) >>> 16;
  assign ys = ({y_r[31], y_r} + 33'sd32768) >>> 16;

  always_comb begin
    c0 = rzero_r ? 16'sd16384 : clamp14(xs[16:0]);
    s0 = rzero_r ? 16'sd0 : clamp14(ys[16:0]);
    unique case (q_r)
      2'd0: begin c_q = c0;  s_q = s0;  end
      2'd1: begin c_q = -s0; s_q = c0;  end
      2'd2: begin c_q = -c0; s_q = -s0; end
      2'd3: begin c_q = s0;  s_q = -c0; end
      default: begin c_q = c0; s_q = s0; end
    endcase
  end

  logic signed [15:0] cp_r, sp_r, ct_r, st_r;
  logic signed [15:0] upx_r, upy_r, wx_r, wy_r;
  logic signed [16:0] ex_r, ey_r, ez_r;

  // shared multiplier with Q14 rounding
  logic signed [16:0] ma;
  logic signed [15:0] mb;
  logic signed [32:0] mp;
  logic signed [33:0] mr;

  always_comb begin
    ma = {cp_r[15], cp_r};
    mb = ct_r;
    unique case (cmd.mstep)
      obc_pkg::MS_UP_X:  begin ma = {cp_r[15], cp_r}; mb = ct_r; end
      obc_pkg::MS_UP_Y:  begin ma = {sp_r[15], sp_r}; mb = ct_r; end
      obc_pkg::MS_W_X:   begin ma = {cp_r[15], cp_r}; mb = st_r; end
      obc_pkg::MS_W_Y:   begin ma = {sp_r[15], sp_r}; mb = st_r; end
      obc_pkg::MS_EYE_X: begin ma = {1'b0, radius_r}; mb = wx_r; end
      obc_pkg::MS_EYE_Y: begin ma = {1'b0, radius_r}; mb = wy_r; end
      obc_pkg::MS_EYE_Z: begin ma = {1'b0, radius_r}; mb = ct_r; end
      default: ;
    endcase
  end

  assign mp = ma * mb;
  assign mr = {mp[32], mp} + 34'sd8192;

  always_ff @(posedge clk) begin
    if (cmd.reduce) begin
      q_r     <= q_nxt;
      r_r     <= r_nxt;
      rzero_r <= (r_nxt == '0);
    end
    if (cmd.seed) begin
      x_r <= obc_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= z_seed;
    end
    if (cmd.rotate) begin
      if (!z_r[31]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (cmd.finish) begin
      if (cmd.sel) begin
        ct_r <= c_q;
        st_r <= s_q;
      end else begin
        cp_r <= c_q;
        sp_r <= s_q;
      end
    end
    if (cmd.mul) begin
      unique case (cmd.mstep)
        obc_pkg::MS_UP_X:  upx_r <= mr[29:14];
        obc_pkg::MS_UP_Y:  upy_r <= mr[29:14];
        obc_pkg::MS_W_X:   wx_r  <= mr[29:14];
        obc_pkg::MS_W_Y:   wy_r  <= mr[29:14];
        obc_pkg::MS_EYE_X: ex_r  <= mr[30:14];
        obc_pkg::MS_EYE_Y: ey_r  <= mr[30:14];
        obc_pkg::MS_EYE_Z: ez_r  <= mr[30:14];
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_data <= {5'b0, ez_r, ey_r, ex_r, 16'(-ct_r), 16'(-wy_r), 16'(-wx_r),
                   16'(-st_r), upy_r, upx_r, 16'sd0, cp_r, 16'(-sp_r)};
    end
  end

`ifndef SYNTHESIS
  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    (az_r <= 18'sd92160) && (az_r >= -18'sd92160))
    else $error("azimuth out of range");
  a_inc_range: assert property (@(posedge clk) disable iff (!rst_n)
    inc_r <= 16'(obc_pkg::HALF_TURN))
    else $error("inclination out of range");
`endif

endmodule
`default_nettype wire

/* hdl/orbit_camera_basis.sv */
`default_nettype none
// Orbit camera basis: angles held in 1/256 degree, basis and eye in fixed point.
// The shared CORDIC loop runs once per angle (reduce, seed, rotate, finish),
// then the multiplies; a new item is taken only once the last one is through,
// but the next item is taken while the last result still waits in the output
// register.
// Reset (rst_n low, synchronous): angles 0, radius 256 (1.0), no result pending.
module orbit_camera_basis (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // input item
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [39:0]   in_tdata,   // azimuth_delta[17:0], inclination_delta[34:18]
  input  wire logic [1:0]    in_tuser,   // op[1:0]
  // result item
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [199:0]       out_tdata,  // right_x, right_y, right_z, up_x, up_y, up_z,
                                         // view_x, view_y, view_z (16 b each),
                                         // eye_x, eye_y, eye_z (17 b each)
  // radius register
  input  wire logic          cfg_tvalid,
  output logic               cfg_tready,
  input  wire logic [15:0]   cfg_tdata   // radius[15:0], unsigned Q8.8
);

  obc_pkg::obc_cmd_t cmd;

  // radius writes are taken only while no item is being worked on
  assign cfg_tready = in_tready;

  // sequencer: update, per angle reduce/seed/rotate/finish, then seven multiplies
  obc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // angle store, CORDIC, shared multiplier and output register
  obc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_tuser),
    .in_az_delta  (in_tdata[17:0]),
    .in_inc_delta (in_tdata[34:18]),
    .cfg_we       (cfg_tvalid && cfg_tready),
    .cfg_radius   (cfg_tdata),
    .out_data     (out_tdata)
  );

`ifndef SYNTHESIS
  a_in_blocked_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && !in_tready) |=> !$rose(in_tready) || out_tvalid)
    else $error("result dropped on return to idle");
`endif

endmodule
`default_nettype wire

/* tb/sv/basis_checker.sv */
`default_nettype none
module basis_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [39:0]  in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [199:0] out_tdata,
  input  wire logic         cfg_tvalid,
  input  wire logic         cfg_tready,
  input  wire logic [15:0]  cfg_tdata,
  output int                errors,
  output int                pending,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_TAB [24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  logic [199:0] basis_due [$];
  longint       cam_azimuth, cam_inclination, cam_radius;

  function automatic longint clamp_unit(input longint v);
    if (v > obc_pkg::ONE_Q14) return obc_pkg::ONE_Q14;
    if (v < -obc_pkg::ONE_Q14) return -obc_pkg::ONE_Q14;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic void angle_sincos(input longint a, output longint c, output longint s);
    longint m, q, r, c0, s0, x, y, z, dx, dy;
    m = a % obc_pkg::FULL_TURN;
    if (m < 0) m += obc_pkg::FULL_TURN;
    q = m / obc_pkg::QUARTER_TURN;
    r = m % obc_pkg::QUARTER_TURN;
    if (r == 0) begin
      c0 = obc_pkg::ONE_Q14;
      s0 = 0;
    end else begin
      x = obc_pkg::CORDIC_GAIN;
      y = 0;
      z = (r <<< 21) / 45;
      for (int i = 0; i < obc_pkg::TRIG_ITERATIONS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TAB[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TAB[i];
        end
      end
      c0 = clamp_unit((x + 32768) >>> 16);
      s0 = clamp_unit((y + 32768) >>> 16);
    end
    case (q)
      0:       begin c = c0;  s = s0;  end
      1:       begin c = -s0; s = c0;  end
      2:       begin c = -c0; s = -s0; end
      default: begin c = s0;  s = -c0; end
    endcase
  endfunction

  // advance the angles for one item and build the packed basis word
  function automatic logic [199:0] predict_basis(input obc_pkg::op_t op,
                                                 input logic [17:0] daz,
                                                 input logic [16:0] dinc);
    longint az, inc, cp, sp, ct, st;
    longint v [12];
    logic [199:0] w;
    case (op)
      obc_pkg::OP_UPDATE: begin
        az  = cam_azimuth + longint'($signed(daz));
        inc = cam_inclination + longint'($signed(dinc));
        if (az > obc_pkg::FULL_TURN || az < -obc_pkg::FULL_TURN) az = 0;
        if (inc > obc_pkg::HALF_TURN) inc = obc_pkg::HALF_TURN;
        if (inc < 0) inc = 0;
      end
      obc_pkg::OP_VIEW_X: begin az = 0; inc = obc_pkg::QUARTER_TURN; end
      obc_pkg::OP_VIEW_Y: begin
        az  = obc_pkg::QUARTER_TURN;
        inc = obc_pkg::QUARTER_TURN;
      end
      default:   begin az = 0; inc = 0; end
    endcase
    cam_azimuth     = az;
    cam_inclination = inc;
    angle_sincos(az, cp, sp);
    angle_sincos(inc, ct, st);
    v[0] = -sp;            v[1] = cp;             v[2] = 0;
    v[3] = qmul(cp, ct);   v[4] = qmul(sp, ct);   v[5] = -st;
    v[6] = -qmul(cp, st);  v[7] = -qmul(sp, st);  v[8] = -ct;
    for (int k = 0; k < 3; k++) v[9+k] = (-cam_radius * v[6+k] + 8192) >>> 14;
    w = '0;
    for (int k = 0; k < 9; k++) w[16*k +: 16] = v[k][15:0];
    for (int k = 0; k < 3; k++) w[144 + 17*k +: 17] = v[9+k][16:0];
    return w;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic string field_name(input int k);
    string names [12] = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z",
                          "view_x", "view_y", "view_z", "eye_x", "eye_y", "eye_z"};
    return names[k];
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    logic [199:0] want;
    if (!rst_n) begin
      cam_azimuth     = 0;
      cam_inclination = 0;
      cam_radius      = obc_pkg::RADIUS_RESET;
      basis_due.delete();
    end else begin
      if (cfg_tvalid && cfg_tready) cam_radius = cfg_tdata;
      if (in_tvalid && in_tready)
        basis_due.push_back(predict_basis(obc_pkg::op_t'(in_tuser), in_tdata[17:0],
                                          in_tdata[34:18]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (basis_due.size() == 0) begin
          $display("%0t result item with nothing expected", $realtime);
          errors++;
        end else begin
          want = basis_due.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_tdata[16*k +: 16] !== want[16*k +: 16])
              report(field_name(k), $signed(out_tdata[16*k +: 16]), $signed(want[16*k +: 16]));
          for (int k = 0; k < 3; k++)
            if (out_tdata[144 + 17*k +: 17] !== want[144 + 17*k +: 17])
              report(field_name(9+k), $signed(out_tdata[144 + 17*k +: 17]),
                     $signed(want[144 + 17*k +: 17]));
        end
      end
    end
    pending = basis_due.size();
  end
endmodule
`default_nettype wire

/* tb/sv/orbit_camera_basis_tb.sv */
`default_nettype none
module orbit_camera_basis_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;   // well above the long output stall
  localparam int DRAIN_CYCLES   = 60;     // extra wait once no result is pending
  localparam int STALL_CYCLES   = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;            // azimuth_delta[17:0], inclination_delta[34:18]
  logic [1:0]   in_tuser = obc_pkg::OP_UPDATE;  // op[1:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;                // 9 x 16 b basis, then 3 x 17 b eye
  logic         cfg_tvalid = 1'b0;
  logic         cfg_tready;
  logic [15:0]  cfg_tdata = '0;           // radius[15:0]

  int  errors, pending, results_seen;
  int  items_sent = 0;
  bit  quiet = 0;        // no idling in the closing stretch
  bit  stall_done = 0;
  int  idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  orbit_camera_basis dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  basis_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_tvalid && cfg_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d result items outstanding", pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off once the run is under way
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!stall_done && items_sent >= 120) begin
        out_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_done = 1;
        out_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_item(input obc_pkg::op_t op, input logic [17:0] daz,
                           input logic [16:0] dinc);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {5'b0, dinc, daz};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3) - 1) @(negedge clk);
    end
  endtask

  // let the block drain before touching the radius
  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radius(input logic [15:0] r);
    drain();
    @(negedge clk);
    cfg_tvalid = 1'b1;
    cfg_tdata  = r;
    do @(posedge clk); while (!cfg_tready);
    @(negedge clk);
    cfg_tvalid = 1'b0;
  endtask

  // mostly small in-range moves, some large, some raw full-width, some axis views
  task automatic random_item;
    int pick;
    logic [17:0] daz;
    logic [16:0] dinc;
    pick = $urandom_range(0, 99);
    daz  = 18'($urandom_range(0, 4095) - 2048);
    dinc = 17'($urandom_range(0, 2047) - 1024);
    if (pick < 15) begin
      daz  = 18'($urandom_range(0, 2 * obc_pkg::FULL_TURN) - obc_pkg::FULL_TURN);
      dinc = 17'($urandom_range(0, 2 * obc_pkg::HALF_TURN) - obc_pkg::HALF_TURN);
    end else if (pick < 25) begin
      daz  = 18'($urandom);
      dinc = 17'($urandom);
    end
    if (pick >= 88)
      send_item(obc_pkg::op_t'($urandom_range(1, 3)), 18'($urandom), 17'($urandom));
    else send_item(obc_pkg::OP_UPDATE, daz, dinc);
  endtask

  initial begin
    logic [15:0] radii [4];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: axis views, reset radius
    send_item(obc_pkg::OP_VIEW_X, 18'h3FFFF, 17'h1FFFF);
    send_item(obc_pkg::OP_VIEW_Y, 18'h00000, 17'h00000);
    send_item(obc_pkg::OP_VIEW_Z, 18'h2AAAA, 17'h15555);
    send_item(obc_pkg::OP_UPDATE, 18'd0, 17'd0);
    // exactly a full turn is kept, one unit more falls back to zero
    send_item(obc_pkg::OP_UPDATE, 18'(obc_pkg::FULL_TURN), 17'(obc_pkg::HALF_TURN));
    send_item(obc_pkg::OP_UPDATE, 18'd1, 17'd1);
    send_item(obc_pkg::OP_UPDATE, 18'(-obc_pkg::FULL_TURN), 17'(-obc_pkg::HALF_TURN));
    send_item(obc_pkg::OP_UPDATE, 18'(-1), 17'(-1));
    send_item(obc_pkg::OP_UPDATE, 18'(-obc_pkg::FULL_TURN), 17'd0);
    // deltas beyond the nominal range, sign-extended from their widths
    send_item(obc_pkg::OP_UPDATE, 18'h1FFFF, 17'h0FFFF);
    send_item(obc_pkg::OP_UPDATE, 18'h20000, 17'h10000);
    send_item(obc_pkg::OP_UPDATE, 18'd100, 17'd23040);
    send_item(obc_pkg::OP_UPDATE, 18'd11520, 17'd1);

    set_radius(16'hFFFF);
    send_item(obc_pkg::OP_VIEW_X, 18'd0, 17'd0);
    send_item(obc_pkg::OP_UPDATE, 18'd5000, 17'd7000);
    send_item(obc_pkg::OP_VIEW_Y, 18'd0, 17'd0);
    set_radius(16'd1);
    send_item(obc_pkg::OP_UPDATE, 18'(-33333), 17'd12345);
    send_item(obc_pkg::OP_VIEW_Z, 18'd0, 17'd0);
    set_radius(16'd0);   // zero radius puts the eye at the origin
    send_item(obc_pkg::OP_UPDATE, 18'd777, 17'd9999);
    send_item(obc_pkg::OP_VIEW_X, 18'd0, 17'd0);

    radii = '{16'd256, 16'hFFFF, 16'(($urandom_range(1, 65535))), 16'd1};
    for (int ph = 0; ph < 4; ph++) begin
      set_radius(ph == 2 ? 16'($urandom_range(1, 65535)) : radii[ph]);
      if (ph == 3) quiet = 1;
      repeat (160) random_item();
    end

    drain();
    $display("%0d input items, %0d results checked, radius 0/1/256/max and random",
             items_sent, results_seen);
    $display("axis views, full-turn reset, inclination clamp and one long output stall covered");
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hdl/obc_pkg.sv
hdl/obc_ctrl.sv
hdl/obc_dp.sv
hdl/orbit_camera_basis.sv
tb/sv/basis_checker.sv
tb/sv/orbit_camera_basis_tb.sv
